// File: rtl/bb3_pkg.sv
// bb3_pkg: shared types, codes and constants of the 3x3 rgb box blur
// no dependencies; compile first

package bb3_pkg;

    localparam int CH_W        = 8;
    localparam int CFG_DW      = 11;
    localparam int CFG_IW      = 1;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = 13;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef enum logic [CFG_IW-1:0]
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed
    {
        logic             pre;
        logic             got;
        logic [2:0]       col_mask;
        logic [2:0]       row_mask;
        logic [CNT_W-1:0] cnt;
        logic             frame_end;
    } emit_ctl_t;

    typedef struct packed
    {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] cnt;
        logic             frame_end;
    } sum_t;

    typedef struct packed
    {
        rgb_t pix;
        logic frame_end;
    } result_t;

    // ceil(2^RECIP_SHIFT / (2*cnt)), exact for every numerator 2*sum+cnt
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd2:    r = 20'd262144;
            4'd3:    r = 20'd174763;
            4'd4:    r = 20'd131072;
            4'd5:    r = 20'd104858;
            4'd6:    r = 20'd87382;
            4'd7:    r = 20'd74899;
            4'd8:    r = 20'd65536;
            4'd9:    r = 20'd58255;
            default: r = 20'd524288;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bb3_ifs.sv
// bb3 channel interfaces: pixel input, result output and register write
// depends on bb3_pkg

interface bb3_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [bb3_pkg::CH_W-1:0]  red;
    logic [bb3_pkg::CH_W-1:0]  green;
    logic [bb3_pkg::CH_W-1:0]  blue;

    modport source (output valid, output kind, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    output ready);
endinterface

interface bb3_out_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::CH_W-1:0]  out_red;
    logic [bb3_pkg::CH_W-1:0]  out_green;
    logic [bb3_pkg::CH_W-1:0]  out_blue;
    logic                      frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

interface bb3_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bb3_pkg::CFG_IW-1:0]  index;
    logic [bb3_pkg::CFG_DW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/bb3_ram.sv
// bb3_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 rgb box blur, top level
// depends on bb3_pkg, bb3_ifs and bb3_ram

// Accepts one item per clock while input ready is high. The two earlier rows
// live in one line ram (read and written once per cycle at the current
// column, with forwarding between back-to-back accesses to the same column);
// that ram port sets the rate. A result is registered in the line ram and
// divide stages before it enters the output queue. A drain tick that flushes
// the first result of a single-row frame steps the window twice and holds
// input ready low for its second step. Input ready drops while four results
// are in flight or queued. Pixels that arrive after the frame's last pixel
// while results are pending are dropped; a register write restarts the frame.

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    bb3_in_if.sink           pixel,
    bb3_out_if.source        result,
    bb3_cfg_if.sink          cfg
);

    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int XW       = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int YW       = $clog2(MAX_HEIGHT + 2);
    localparam int PW       = $clog2(MAX_WIDTH + 2);
    localparam int W_RST    = MAX_WIDTH < 1024 ? MAX_WIDTH : 1024;
    localparam int H_RST    = MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024;
    localparam int PIX_W    = $bits(bb3_pkg::rgb_t);
    localparam int LINE_W   = 2 * PIX_W;
    localparam int FIFO_D   = 4;
    localparam int FP_W     = $clog2(FIFO_D);
    localparam int OCC_W    = 3;
    localparam int PROD_W   = bb3_pkg::NUM_W + bb3_pkg::RECIP_W;

    // frame size and position
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic          again_reg, again_next;

    // line ram stage
    logic                  b_valid_reg;
    logic [XW-1:0]         b_addr_reg;
    bb3_pkg::rgb_t         b_pix_reg;
    bb3_pkg::emit_ctl_t    b_ctl_reg;
    logic                  fwd_reg;
    logic [LINE_W-1:0]     fwd_data_reg;
    bb3_pkg::rgb_t         win_reg [3][3];

    // divide stage
    logic                  c_valid_reg;
    bb3_pkg::sum_t         c_sum_reg;

    // output queue
    bb3_pkg::result_t      fifo_reg [FIFO_D];
    logic [FP_W-1:0]       head_reg;
    logic [FP_W-1:0]       tail_reg;
    logic [FP_W:0]         cnt_reg;

    logic                  accept_in;
    logic                  is_drain;
    logic [YW-1:0]         h_ext;
    logic                  in_frame;
    logic                  pix_adv;
    logic                  drn_adv;
    logic                  adv;
    logic                  emit_pre;
    logic                  emit_post;
    logic                  got;
    logic [WW-1:0]         col_inc;
    logic                  wrap;
    bb3_pkg::emit_ctl_t    a_ctl;
    bb3_pkg::rgb_t         a_pix;
    logic                  cfg_wr;
    logic [WW-1:0]         cfg_w;
    logic [HW-1:0]         cfg_h;
    logic [OCC_W-1:0]      occ;

    logic [LINE_W-1:0]     ram_rdata;
    logic [LINE_W-1:0]     line_rdata;
    logic [LINE_W-1:0]     line_wdata;
    bb3_pkg::rgb_t         up_pix;
    bb3_pkg::rgb_t         mid_pix;
    bb3_pkg::rgb_t         win_after [3][3];
    bb3_pkg::rgb_t         win_use [3][3];
    bb3_pkg::sum_t         b_sum;
    logic                  fwd_next;

    logic [bb3_pkg::NUM_W-1:0]   num_r, num_g, num_b;
    logic [bb3_pkg::RECIP_W-1:0] rcp;
    logic [PROD_W-1:0]           prod_r, prod_g, prod_b;
    bb3_pkg::result_t            c_res;
    logic                        push;
    logic                        pop;

    // input side
    assign accept_in = pixel.valid && pixel.ready;
    assign is_drain  = pixel.kind == bb3_pkg::KIND_DRAIN;
    assign h_ext     = YW'(h_reg);
    assign in_frame  = row_reg < h_ext;
    assign pix_adv   = accept_in && !is_drain && in_frame;
    assign drn_adv   = accept_in && is_drain && !in_frame && (pend_reg != '0);
    assign adv       = pix_adv || drn_adv || again_reg;

    assign emit_pre  = (col_reg == '0) && (row_reg >= YW'(2));
    assign emit_post = (col_reg != '0) && (row_reg != '0);
    assign got       = emit_pre || emit_post;
    assign col_inc   = WW'(col_reg) + WW'(1);
    assign wrap      = col_inc >= w_reg;

    assign occ = OCC_W'(b_valid_reg && b_ctl_reg.got) + OCC_W'(c_valid_reg) + OCC_W'(cnt_reg);
    assign pixel.ready = !again_reg && (occ < OCC_W'(FIFO_D));

    always_comb
    begin
        a_ctl.pre  = emit_pre;
        a_ctl.got  = got;
        if (emit_pre)
        begin
            a_ctl.col_mask = {1'b1, w_reg != WW'(1), 1'b0};
            a_ctl.row_mask = {row_reg <= h_ext, 1'b1, row_reg >= YW'(3)};
        end
        else
        begin
            a_ctl.col_mask = {1'b1, 1'b1, col_reg > XW'(1)};
            a_ctl.row_mask = {row_reg < h_ext, row_reg <= h_ext, row_reg >= YW'(2)};
        end
        a_ctl.cnt = bb3_pkg::CNT_W'($countones(a_ctl.col_mask))
                  * bb3_pkg::CNT_W'($countones(a_ctl.row_mask));
        a_ctl.frame_end = emit_pre && (row_reg == h_ext + YW'(1));
    end

    always_comb
    begin
        if (again_reg || is_drain)
        begin
            a_pix = '0;
        end
        else
        begin
            a_pix.red   = pixel.red;
            a_pix.green = pixel.green;
            a_pix.blue  = pixel.blue;
        end
    end

    // register writes, size saturated to 1..max
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cfg_w = (cfg.data == '0) ? WW'(1)
                 : (32'(cfg.data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.data);
    assign cfg_h = (cfg.data == '0) ? HW'(1)
                 : (32'(cfg.data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.data);

    always_comb
    begin
        w_next     = w_reg;
        h_next     = h_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        again_next = drn_adv && !got;
        if (adv)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = row_reg + YW'(1);
            end
            else
            begin
                col_next = XW'(col_inc);
            end
        end
        if (pix_adv && !got)
        begin
            pend_next = pend_reg + PW'(1);
        end
        if ((drn_adv || again_reg) && got)
        begin
            pend_next = pend_reg - PW'(1);
            if (pend_reg == PW'(1))
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        if (cfg_wr)
        begin
            case (cfg.index)
                bb3_pkg::REG_FRAME_WIDTH:  w_next = cfg_w;
                bb3_pkg::REG_FRAME_HEIGHT: h_next = cfg_h;
                default:                   w_next = w_reg;
            endcase
            col_next   = '0;
            row_next   = '0;
            pend_next  = '0;
            again_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= WW'(W_RST);
            h_reg     <= HW'(H_RST);
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            again_reg <= 1'b0;
        end
        else
        begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            again_reg <= again_next;
        end
    end

    // line ram: {upper row, middle row} per column
    bb3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (line_wdata),
        .re    (adv),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign line_rdata = fwd_reg ? fwd_data_reg : ram_rdata;
    assign up_pix     = bb3_pkg::rgb_t'(line_rdata[LINE_W-1:PIX_W]);
    assign mid_pix    = bb3_pkg::rgb_t'(line_rdata[PIX_W-1:0]);
    assign line_wdata = {mid_pix, b_pix_reg};
    assign fwd_next   = adv && b_valid_reg && (col_reg == b_addr_reg);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_after[0][r] = win_reg[1][r];
            win_after[1][r] = win_reg[2][r];
        end
        win_after[2][0] = up_pix;
        win_after[2][1] = mid_pix;
        win_after[2][2] = b_pix_reg;
        for (int s = 0; s < 3; s++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_use[s][r] = b_ctl_reg.pre ? win_reg[s][r] : win_after[s][r];
            end
        end
    end

    always_comb
    begin
        b_sum.red       = '0;
        b_sum.green     = '0;
        b_sum.blue      = '0;
        b_sum.cnt       = b_ctl_reg.cnt;
        b_sum.frame_end = b_ctl_reg.frame_end;
        for (int s = 0; s < 3; s++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (b_ctl_reg.col_mask[s] && b_ctl_reg.row_mask[r])
                begin
                    b_sum.red   = b_sum.red   + bb3_pkg::SUM_W'(win_use[s][r].red);
                    b_sum.green = b_sum.green + bb3_pkg::SUM_W'(win_use[s][r].green);
                    b_sum.blue  = b_sum.blue  + bb3_pkg::SUM_W'(win_use[s][r].blue);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg   <= col_reg;
        b_pix_reg    <= a_pix;
        b_ctl_reg    <= a_ctl;
        fwd_data_reg <= line_wdata;
        c_sum_reg    <= b_sum;
        if (b_valid_reg)
        begin
            for (int s = 0; s < 3; s++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[s][r] <= win_after[s][r];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= adv;
            fwd_reg     <= fwd_next;
            c_valid_reg <= b_valid_reg && b_ctl_reg.got;
        end
    end

    // rounded mean: (2*sum+cnt)/(2*cnt) by reciprocal
    assign rcp    = bb3_pkg::recip(c_sum_reg.cnt);
    assign num_r  = {c_sum_reg.red, 1'b0} + bb3_pkg::NUM_W'(c_sum_reg.cnt);
    assign num_g  = {c_sum_reg.green, 1'b0} + bb3_pkg::NUM_W'(c_sum_reg.cnt);
    assign num_b  = {c_sum_reg.blue, 1'b0} + bb3_pkg::NUM_W'(c_sum_reg.cnt);
    assign prod_r = PROD_W'(num_r) * PROD_W'(rcp);
    assign prod_g = PROD_W'(num_g) * PROD_W'(rcp);
    assign prod_b = PROD_W'(num_b) * PROD_W'(rcp);

    assign c_res.pix.red   = prod_r[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
    assign c_res.pix.green = prod_g[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
    assign c_res.pix.blue  = prod_b[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
    assign c_res.frame_end = c_sum_reg.frame_end;

    // output queue
    assign push = c_valid_reg;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[tail_reg] <= c_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + FP_W'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + FP_W'(1);
            end
            cnt_reg <= cnt_reg + (FP_W + 1)'(push) - (FP_W + 1)'(pop);
        end
    end

    assign result.valid     = cnt_reg != '0;
    assign result.out_red   = fifo_reg[head_reg].pix.red;
    assign result.out_green = fifo_reg[head_reg].pix.green;
    assign result.out_blue  = fifo_reg[head_reg].pix.blue;
    assign result.frame_end = fifo_reg[head_reg].frame_end;

endmodule
